// ----- src/smh_pkg.sv -----
// Shared widths, register codes, and sequencer states for the smoothed histogram.
package smh_pkg;

    localparam int NUM_BINS_DEF = 64;

    localparam int PIX_W      = 16;
    localparam int MASK_W     = 8;
    localparam int MATCH_W    = 9;
    localparam int COUNT_W    = 25;
    localparam int COEF_W     = 16;
    localparam int COORD_W    = 13;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 13;
    localparam int IDX_OUT_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COL_W-1:0]   COL_MAX   = '1;
    localparam logic [ROW_W-1:0]   ROW_MAX   = '1;

    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASK_MATCH    = 3'd0,
        REG_SMOOTH_LEVEL  = 3'd1,
        REG_FRAME_WIDTH   = 3'd2,
        REG_REGION_LEFT   = 3'd3,
        REG_REGION_TOP    = 3'd4,
        REG_REGION_RIGHT  = 3'd5,
        REG_REGION_BOTTOM = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_ACC,
        ST_DRAIN,
        ST_SEED_RD,
        ST_SEED_LD,
        ST_SM_RD,
        ST_SM_MUL,
        ST_SM_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

endpackage

// ----- src/smh_bin_ram.sv -----
// Bin count memory: one write port, one read port with registered read data.
module smh_bin_ram import smh_pkg::*; #(
    parameter int DEPTH = NUM_BINS_DEF,
    parameter int AW    = $clog2(NUM_BINS_DEF),
    parameter int DW    = COUNT_W
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/smh_blend.sv -----
// Smoothing step: registered |nb - self| * coef, then self moved toward nb by the product's top.
module smh_blend import smh_pkg::*; (
    input  logic              aclk,
    input  logic              load,
    input  count_t            self_val,
    input  count_t            nb_val,
    input  logic [COEF_W-1:0] coef,
    output count_t            result
);

    localparam int MAG_W = COUNT_W + COEF_W;

    logic             up_next;
    count_t           diff;
    logic             up_reg;
    count_t           base_reg;
    logic [MAG_W-1:0] mag_reg;
    count_t           step;

    always_comb begin
        up_next = (nb_val >= self_val);
        diff    = up_next ? (nb_val - self_val) : (self_val - nb_val);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            up_reg   <= up_next;
            base_reg <= self_val;
            mag_reg  <= MAG_W'(diff) * MAG_W'(coef);
        end
    end

    assign step   = mag_reg[MAG_W-1:COEF_W];
    assign result = up_reg ? (base_reg + step) : (base_reg - step);

endmodule

// ----- src/smoothed_masked_histogram.sv -----
// Masked, windowed histogram with two-pass smoothing; top level and frame sequencer.
// Pixels: one transfer per cycle while counting; the count update is a read-modify-write
//   on the bin memory with forwarding of the previous write.
// Frame end: a drain state, a seed read and load of bin 0, then a forward and a backward
//   smoothing pass (memory read, multiply and write-back per bin), then each bin read out.
// Reset: synchronous, active low; then a clearing pass that writes zero to every bin.
module smoothed_masked_histogram import smh_pkg::*; #(
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel_value,
    input  logic [MASK_W-1:0]     s_mask_value,
    input  logic                  s_last_pixel,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IDX_OUT_W-1:0]  m_bin_index,
    output logic [COUNT_W-1:0]    m_bin_count,
    output logic                  m_last_bin,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BIN_AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int BIN_SPAN   = 65536 / NUM_BINS;
    localparam int SPAN_LOG   = $clog2(BIN_SPAN);
    localparam int RECIP_SH   = PIX_W + SPAN_LOG;
    localparam int PROD_W     = 2 * PIX_W + 1;
    localparam logic [47:0] RECIP_WIDE =
        ((48'd1 << RECIP_SH) + 48'(BIN_SPAN) - 48'd1) / 48'(BIN_SPAN);
    localparam logic [PIX_W:0]    RECIP   = RECIP_WIDE[PIX_W:0];
    localparam logic [BIN_AW-1:0] BIN_TOP = BIN_AW'(NUM_BINS - 1);

    // configuration
    logic [MATCH_W-1:0] mask_match_reg;
    logic [COEF_W-1:0]  smooth_level_reg;
    logic [COORD_W-1:0] frame_width_reg;
    logic [COORD_W-1:0] region_left_reg;
    logic [COORD_W-1:0] region_top_reg;
    logic [COORD_W-1:0] region_right_reg;
    logic [COORD_W-1:0] region_bottom_reg;

    // sequencer and datapath
    state_t             state_reg, state_next;
    logic [BIN_AW-1:0]  idx_reg, idx_next;
    logic               back_reg, back_next;
    count_t             prev_reg, prev_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               s1_cnt_reg, s1_cnt_next;
    logic [BIN_AW-1:0]  s1_bin_reg, s1_bin_next;
    logic               fwd_en_reg;
    logic [BIN_AW-1:0]  fwd_addr_reg;
    count_t             fwd_data_reg;
    logic               m_valid_reg, m_valid_next;
    logic [IDX_OUT_W-1:0] m_bin_index_reg, m_bin_index_next;
    count_t             m_bin_count_reg, m_bin_count_next;
    logic               m_last_bin_reg, m_last_bin_next;

    // memory and blend ports
    logic               wr_en;
    logic [BIN_AW-1:0]  wr_addr;
    count_t             wr_data;
    logic [BIN_AW-1:0]  rd_addr;
    count_t             rd_data;
    logic               blend_load;
    count_t             blend_result;

    logic               accept;
    logic               m_xfer;
    logic               selected;
    logic               in_region;
    logic [COORD_W-1:0] col_inc;
    logic               row_end;
    logic [PROD_W-1:0]  bin_prod;
    logic [PROD_W-1:0]  bin_quot;
    logic [BIN_AW-1:0]  bin_sel;
    count_t             acc_old;
    count_t             acc_new;

    smh_bin_ram #(
        .DEPTH (NUM_BINS),
        .AW    (BIN_AW),
        .DW    (COUNT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smh_blend u_blend (
        .aclk     (aclk),
        .load     (blend_load),
        .self_val (rd_data),
        .nb_val   (prev_reg),
        .coef     (smooth_level_reg),
        .result   (blend_result)
    );

    assign accept    = s_valid && s_ready;
    assign m_xfer    = m_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    // pixel classification and bin select (reciprocal multiply, exact for 16-bit pixels)
    always_comb begin
        selected  = mask_match_reg[MATCH_W-1] || (s_mask_value == mask_match_reg[MASK_W-1:0]);
        in_region = (COORD_W'(col_reg) >= region_left_reg) &&
                    (COORD_W'(col_reg) < region_right_reg) &&
                    (row_reg >= region_top_reg) && (row_reg < region_bottom_reg);
        col_inc  = COORD_W'(col_reg) + COORD_W'(1);
        row_end  = (col_inc >= frame_width_reg) || (col_reg == COL_MAX);
        bin_prod = PROD_W'(s_pixel_value) * PROD_W'(RECIP);
        bin_quot = bin_prod >> RECIP_SH;
        bin_sel  = (bin_quot > PROD_W'(NUM_BINS - 1)) ? BIN_TOP : bin_quot[BIN_AW-1:0];
        acc_old  = (fwd_en_reg && (fwd_addr_reg == s1_bin_reg)) ? fwd_data_reg : rd_data;
        acc_new  = (acc_old == COUNT_MAX) ? acc_old : (acc_old + count_t'(1));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (idx_reg == BIN_TOP) state_next = ST_ACC;
            ST_ACC:      if (accept && s_last_pixel) state_next = ST_DRAIN;
            ST_DRAIN:    state_next = ST_SEED_RD;
            ST_SEED_RD:  state_next = ST_SEED_LD;
            ST_SEED_LD:  state_next = ST_SM_RD;
            ST_SM_RD:    state_next = ST_SM_MUL;
            ST_SM_MUL:   state_next = ST_SM_WR;
            ST_SM_WR: begin
                if (back_reg && (idx_reg == '0)) begin
                    state_next = ST_OUT_RD;
                end else begin
                    state_next = ST_SM_RD;
                end
            end
            ST_OUT_RD:   state_next = ST_OUT_LD;
            ST_OUT_LD:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (m_xfer) begin
                    state_next = (idx_reg == BIN_TOP) ? ST_ACC : ST_OUT_RD;
                end
            end
            default:     state_next = ST_CLEAR;
        endcase
    end

    // outputs: handshake and memory controls
    always_comb begin
        s_ready    = 1'b0;
        rd_addr    = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = '0;
        blend_load = 1'b0;
        if (s1_cnt_reg) begin
            wr_en   = 1'b1;
            wr_addr = s1_bin_reg;
            wr_data = acc_new;
        end
        case (state_reg)
            ST_CLEAR:   wr_en = 1'b1;
            ST_ACC: begin
                s_ready = 1'b1;
                rd_addr = bin_sel;
            end
            ST_SEED_RD: rd_addr = '0;
            ST_SM_MUL:  blend_load = 1'b1;
            ST_SM_WR: begin
                wr_en   = 1'b1;
                wr_data = blend_result;
            end
            ST_OUT_LD:  wr_en = 1'b1;
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        idx_next         = idx_reg;
        back_next        = back_reg;
        prev_next        = prev_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        s1_cnt_next      = accept && selected && in_region;
        s1_bin_next      = bin_sel;
        m_valid_next     = m_valid_reg;
        m_bin_index_next = m_bin_index_reg;
        m_bin_count_next = m_bin_count_reg;
        m_last_bin_next  = m_last_bin_reg;

        if (accept) begin
            if (s_last_pixel) begin
                col_next = '0;
                row_next = '0;
            end else if (row_end) begin
                col_next = '0;
                row_next = (row_reg == ROW_MAX) ? row_reg : (row_reg + ROW_W'(1));
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end

        case (state_reg)
            ST_CLEAR: idx_next = (idx_reg == BIN_TOP) ? '0 : (idx_reg + BIN_AW'(1));
            ST_SEED_LD: begin
                prev_next = rd_data;
                idx_next  = BIN_AW'(1);
                back_next = 1'b0;
            end
            ST_SM_WR: begin
                prev_next = blend_result;
                if (!back_reg) begin
                    if (idx_reg == BIN_TOP) begin
                        back_next = 1'b1;
                        idx_next  = BIN_TOP - BIN_AW'(1);
                    end else begin
                        idx_next = idx_reg + BIN_AW'(1);
                    end
                end else if (idx_reg != '0) begin
                    idx_next = idx_reg - BIN_AW'(1);
                end
            end
            ST_OUT_LD: begin
                m_valid_next     = 1'b1;
                m_bin_index_next = IDX_OUT_W'(idx_reg);
                m_bin_count_next = rd_data;
                m_last_bin_next  = (idx_reg == BIN_TOP);
            end
            ST_OUT_WAIT: begin
                if (m_xfer) begin
                    m_valid_next = 1'b0;
                    idx_next     = (idx_reg == BIN_TOP) ? '0 : (idx_reg + BIN_AW'(1));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            idx_reg           <= '0;
            back_reg          <= 1'b0;
            col_reg           <= '0;
            row_reg           <= '0;
            s1_cnt_reg        <= 1'b0;
            fwd_en_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
            mask_match_reg    <= MATCH_W'(256);
            smooth_level_reg  <= '0;
            frame_width_reg   <= COORD_W'(4096);
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_right_reg  <= COORD_W'(4096);
            region_bottom_reg <= COORD_W'(4096);
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            back_reg    <= back_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            s1_cnt_reg  <= s1_cnt_next;
            fwd_en_reg  <= wr_en;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MASK_MATCH:    mask_match_reg    <= cfg_data[MATCH_W-1:0];
                    REG_SMOOTH_LEVEL:  smooth_level_reg  <= cfg_data[COEF_W-1:0];
                    REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[COORD_W-1:0];
                    REG_REGION_LEFT:   region_left_reg   <= cfg_data[COORD_W-1:0];
                    REG_REGION_TOP:    region_top_reg    <= cfg_data[COORD_W-1:0];
                    REG_REGION_RIGHT:  region_right_reg  <= cfg_data[COORD_W-1:0];
                    REG_REGION_BOTTOM: region_bottom_reg <= cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg        <= prev_next;
        s1_bin_reg      <= s1_bin_next;
        fwd_addr_reg    <= wr_addr;
        fwd_data_reg    <= wr_data;
        m_bin_index_reg <= m_bin_index_next;
        m_bin_count_reg <= m_bin_count_next;
        m_last_bin_reg  <= m_last_bin_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_index = m_bin_index_reg;
    assign m_bin_count = m_bin_count_reg;
    assign m_last_bin  = m_last_bin_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("pixel intake open while a bin is pending");

    a_last_stops_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_pixel) |=> !s_ready)
        else $error("intake still open after frame end");

    a_last_bin_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_bin) |=> !m_valid)
        else $error("bin output after last bin");

    a_bin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bin_index <= IDX_OUT_W'(NUM_BINS - 1)))
        else $error("bin index out of range");

    a_count_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_cnt_reg |-> (state_reg == ST_ACC || state_reg == ST_DRAIN))
        else $error("count update outside counting phase");

endmodule

// ----- verif/tb_smoothed_masked_histogram.sv -----
// Self-checking testbench for smoothed_masked_histogram: directed table and random frames.
module tb_smoothed_masked_histogram;
    import smh_pkg::*;

    localparam int NUM_BINS      = NUM_BINS_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [IDX_OUT_W-1:0] idx;
        count_t               count;
        logic                 last;
    } bin_result_t;

    typedef enum logic {ROW_REG, ROW_PIXEL} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [PIX_W-1:0]      pix;
        logic [MASK_W-1:0]     mask;
        logic                  last;
        logic                  has_known;
        int                    known_bin;
        count_t                known_count;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel_value = '0;
    logic [MASK_W-1:0]     s_mask_value  = '0;
    logic                  s_last_pixel  = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [IDX_OUT_W-1:0]  m_bin_index;
    logic [COUNT_W-1:0]    m_bin_count;
    logic                  m_last_bin;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    logic [MATCH_W-1:0] mask_sel;
    logic [COEF_W-1:0]  smooth_coef;
    logic [COORD_W-1:0] frame_w;
    logic [COORD_W-1:0] win_left;
    logic [COORD_W-1:0] win_top;
    logic [COORD_W-1:0] win_right;
    logic [COORD_W-1:0] win_bottom;
    count_t             hist [NUM_BINS];
    logic [COL_W-1:0]   col_pos;
    logic [ROW_W-1:0]   row_pos;

    bin_result_t awaited_bins[$];
    stim_row_t   directed[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    smoothed_masked_histogram dut (.*);

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic count_t smooth_toward(count_t self_cnt, count_t nb_cnt);
        logic [63:0] mag;
        if (nb_cnt >= self_cnt) begin
            mag = (64'(nb_cnt) - 64'(self_cnt)) * 64'(smooth_coef);
            return self_cnt + count_t'(mag >> 16);
        end
        mag = (64'(self_cnt) - 64'(nb_cnt)) * 64'(smooth_coef);
        return self_cnt - count_t'(mag >> 16);
    endfunction

    function automatic void tally_pixel(logic [PIX_W-1:0] pix, logic [MASK_W-1:0] mask,
                                        logic last);
        int          b;
        bin_result_t r;
        if ((mask_sel[MATCH_W-1] || mask == mask_sel[7:0]) &&
            col_pos >= win_left && col_pos < win_right &&
            row_pos >= win_top && row_pos < win_bottom) begin
            b = int'(pix) / (65536 / NUM_BINS);
            if (b > NUM_BINS - 1) begin
                b = NUM_BINS - 1;
            end
            if (hist[b] != COUNT_MAX) begin
                hist[b] = hist[b] + 1'b1;
            end
        end
        if (int'(col_pos) + 1 >= int'(frame_w) || col_pos == COL_MAX) begin
            col_pos = '0;
            if (row_pos != ROW_MAX) begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
        if (last) begin
            for (int i = 1; i < NUM_BINS; i++) begin
                hist[i] = smooth_toward(hist[i], hist[i-1]);
            end
            for (int i = NUM_BINS - 1; i > 0; i--) begin
                hist[i-1] = smooth_toward(hist[i-1], hist[i]);
            end
            for (int i = 0; i < NUM_BINS; i++) begin
                r.idx   = IDX_OUT_W'(i);
                r.count = hist[i];
                r.last  = (i == NUM_BINS - 1);
                awaited_bins.push_back(r);
                hist[i] = '0;
            end
            col_pos = '0;
            row_pos = '0;
        end
    endfunction

    function automatic void add_reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row.kind        = ROW_REG;
        row.reg_idx     = idx;
        row.reg_data    = data;
        row.pix         = '0;
        row.mask        = '0;
        row.last        = 1'b0;
        row.has_known   = 1'b0;
        row.known_bin   = 0;
        row.known_count = '0;
        directed.push_back(row);
    endfunction

    function automatic void add_pixel_row(logic [PIX_W-1:0] pix, logic [MASK_W-1:0] mask,
                                          logic last, logic has_known, int known_bin,
                                          count_t known_count);
        stim_row_t row;
        row.kind        = ROW_PIXEL;
        row.reg_idx     = '0;
        row.reg_data    = '0;
        row.pix         = pix;
        row.mask        = mask;
        row.last        = last;
        row.has_known   = has_known;
        row.known_bin   = known_bin;
        row.known_count = known_count;
        directed.push_back(row);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_MASK_MATCH:    mask_sel    = data[MATCH_W-1:0];
            REG_SMOOTH_LEVEL:  smooth_coef = data[COEF_W-1:0];
            REG_FRAME_WIDTH:   frame_w     = data[COORD_W-1:0];
            REG_REGION_LEFT:   win_left    = data[COORD_W-1:0];
            REG_REGION_TOP:    win_top     = data[COORD_W-1:0];
            REG_REGION_RIGHT:  win_right   = data[COORD_W-1:0];
            REG_REGION_BOTTOM: win_bottom  = data[COORD_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [MASK_W-1:0] mask,
                              input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_value <= pix;
        s_mask_value  <= mask;
        s_last_pixel  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tally_pixel(pix, mask, last);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (awaited_bins.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_bins.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual bin %0d count %0d last %0b",
                         $time, m_bin_index, m_bin_count, m_last_bin);
                fail_count++;
            end else begin
                want = awaited_bins.pop_front();
                if (m_bin_index !== want.idx) begin
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, want.idx, m_bin_index);
                    fail_count++;
                end
                if (m_bin_count !== want.count) begin
                    $display("%0t: bin %0d bin_count expected %0d actual %0d",
                             $time, want.idx, want.count, m_bin_count);
                    fail_count++;
                end
                if (m_last_bin !== want.last) begin
                    $display("%0t: bin %0d last_bin expected %0b actual %0b",
                             $time, want.idx, want.last, m_last_bin);
                    fail_count++;
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        stim_row_t        row;
        bin_result_t      patched;
        int               pos;
        int               items;
        int               frame_len;
        logic [PIX_W-1:0] pix;
        logic [MASK_W-1:0] mask;
        logic [15:0]      v;

        mask_sel    = 9'h100;
        smooth_coef = '0;
        frame_w     = 13'd4096;
        win_left    = '0;
        win_top     = '0;
        win_right   = 13'd4096;
        win_bottom  = 13'd4096;
        foreach (hist[i]) hist[i] = '0;
        col_pos = '0;
        row_pos = '0;

        // reset values: everything counted, no smoothing
        add_pixel_row(16'h0000, 8'h00, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'hFFFF, 8'hFF, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h03FF, 8'h55, 1'b1, 1'b1, 0, 25'd2);
        add_pixel_row(16'hFFFF, 8'h00, 1'b1, 1'b1, 63, 25'd1);
        // exact mask match, upper data bits ignored
        add_reg_row(REG_MASK_MATCH, 16'hFEA5);
        add_pixel_row(16'h0400, 8'hA5, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h07FF, 8'hA4, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h0400, 8'h25, 1'b1, 1'b1, 1, 25'd1);
        add_reg_row(REG_MASK_MATCH, 16'hFFA5);
        add_reg_row(REG_SMOOTH_LEVEL, 16'hFFFF);
        add_pixel_row(16'h0000, 8'h13, 1'b1, 1'b0, 0, '0);
        add_reg_row(REG_SMOOTH_LEVEL, 16'h8000);
        add_pixel_row(16'h0C00, 8'h00, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h0C00, 8'h01, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h1000, 8'h02, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'hF000, 8'h03, 1'b1, 1'b0, 0, '0);
        // zero width: one row per pixel, rows 1 and 2 counted
        add_reg_row(REG_SMOOTH_LEVEL, 16'h0000);
        add_reg_row(REG_FRAME_WIDTH, 16'h0000);
        add_reg_row(REG_REGION_TOP, 16'd1);
        add_reg_row(REG_REGION_BOTTOM, 16'd3);
        add_pixel_row(16'h1000, 8'h10, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h1000, 8'h11, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h1000, 8'h12, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h1000, 8'h13, 1'b1, 1'b1, 4, 25'd2);
        // two-pixel rows, only column 1 counted
        add_reg_row(REG_FRAME_WIDTH, 16'd2);
        add_reg_row(REG_REGION_TOP, 16'd0);
        add_reg_row(REG_REGION_BOTTOM, 16'hFFFF);
        add_reg_row(REG_REGION_LEFT, 16'd1);
        add_reg_row(REG_REGION_RIGHT, 16'd2);
        add_pixel_row(16'h2000, 8'h00, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h2000, 8'h00, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h2000, 8'h00, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h2000, 8'h00, 1'b1, 1'b1, 8, 25'd2);
        // inverted window
        add_reg_row(REG_REGION_LEFT, 16'h1FFF);
        add_reg_row(REG_REGION_RIGHT, 16'hE000);
        add_pixel_row(16'hFFFF, 8'hFF, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'hFFFF, 8'hFF, 1'b1, 1'b1, 63, 25'd0);
        add_reg_row(REG_REGION_LEFT, 16'd0);
        add_reg_row(REG_REGION_RIGHT, 16'd8191);
        add_reg_row(REG_FRAME_WIDTH, 16'd8191);
        add_reg_row(REG_UNUSED, 16'hFFFF);
        add_reg_row(REG_SMOOTH_LEVEL, 16'hFFFF);
        add_reg_row(REG_MASK_MATCH, 16'h0000);
        add_pixel_row(16'h8000, 8'h00, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h7FFF, 8'h01, 1'b0, 1'b0, 0, '0);
        add_pixel_row(16'h0001, 8'h00, 1'b1, 1'b0, 0, '0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[n]) begin
            row = directed[n];
            if (row.kind == ROW_REG) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_pixel(row.pix, row.mask, row.last);
                if (row.has_known) begin
                    pos = awaited_bins.size() - NUM_BINS + row.known_bin;
                    patched = awaited_bins[pos];
                    patched.count = row.known_count;
                    awaited_bins[pos] = patched;
                end
            end
        end
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 60;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 60;
                end
                default: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 28;
                end
            endcase

            case ($urandom_range(0, 3))
                0:       v = 16'h0000;
                1:       v = 16'h00FF;
                2:       v = 16'h0100 | 16'($urandom_range(0, 255));
                default: v = 16'($urandom_range(0, 255));
            endcase
            write_reg(REG_MASK_MATCH, {7'($urandom), v[8:0]});
            case ($urandom_range(0, 2))
                0:       v = 16'h0000;
                1:       v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            write_reg(REG_SMOOTH_LEVEL, v);
            case ($urandom_range(0, 5))
                0:       v = 16'd0;
                1:       v = 16'd1;
                2:       v = 16'd8191;
                3:       v = 16'd4096;
                default: v = 16'($urandom_range(2, 6));
            endcase
            write_reg(REG_FRAME_WIDTH, {3'($urandom), v[12:0]});
            write_reg(REG_REGION_LEFT, {3'($urandom), 13'($urandom_range(0, 3))});
            write_reg(REG_REGION_TOP, {3'($urandom), 13'($urandom_range(0, 2))});
            v = $urandom_range(0, 1) ? 16'd8191 : 16'($urandom_range(0, 8));
            write_reg(REG_REGION_RIGHT, {3'($urandom), v[12:0]});
            v = $urandom_range(0, 1) ? 16'd8191 : 16'($urandom_range(0, 8));
            write_reg(REG_REGION_BOTTOM, {3'($urandom), v[12:0]});

            items = 0;
            while (items < 5) begin
                frame_len = $urandom_range(1, 12);
                for (int n = 0; n < frame_len; n++) begin
                    case ($urandom_range(0, 9))
                        0:       pix = '0;
                        1:       pix = '1;
                        default: pix = 16'($urandom);
                    endcase
                    mask = ($urandom_range(0, 9) < 7) ? mask_sel[7:0] : 8'($urandom);
                    send_pixel(pix, mask, n == frame_len - 1);
                end
                items += frame_len;
            end
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
